### rtl/core/jsrg_pkg.sv
// ============================================================================
// jsrg_pkg
// shared types, constants and the microprogram of the setpoint ramp generator
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package jsrg_pkg;

    localparam int PERIOD_MS_DEFAULT = 1;

    // input item kinds
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_HOME  = 2'd1;
    localparam logic [1:0] FUNC_FORCE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_STROKE_MAX  = 3'd0;
    localparam logic [2:0] REG_STROKE_MIN  = 3'd1;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd2;
    localparam logic [2:0] REG_ACCEL_LIMIT = 3'd3;
    localparam logic [2:0] REG_ACCEL_RECIP = 3'd4;
    localparam logic [2:0] REG_BRAKE_WIN   = 3'd5;

    // configuration reset values
    localparam logic [30:0] ACCEL_LIMIT_RST = 31'd65536;
    localparam logic [30:0] ACCEL_RECIP_RST = 31'd65536;
    localparam logic [30:0] BRAKE_WIN_RST   = 31'd655360;

    // time step divide by 1000, split as quotient and remainder
    localparam int          TS_DIV      = 1000;
    localparam int          DIV_M_W     = 29;
    localparam logic [28:0] DIV_M       = 29'h10624DD3;
    localparam int          DIV_SHIFT   = 38;
    localparam int          SMALL_M_W   = 21;
    localparam logic [20:0] SMALL_M     = 21'd1073742;
    localparam int          SMALL_SHIFT = 30;

    typedef logic [4:0] step_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TARGET,
        OP_ERR,
        OP_PRED,
        OP_BRAKE,
        OP_ACLAMP,
        OP_TS_ABS,
        OP_TS_MUL1,
        OP_TS_SPLIT,
        OP_TS_MUL2,
        OP_TS_MUL3,
        OP_TS_SUM,
        OP_TS_SIGN,
        OP_VEL_ADD,
        OP_VEL_CLAMP,
        OP_POS_ADD,
        OP_POS_CLIP,
        OP_SET_POS
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_TICK,
        C_PASS2
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  last;
    } ucode_t;

    typedef struct packed {
        logic        load;
        op_t         op;
    } dp_ctrl_t;

    typedef struct packed {
        logic not_tick;
        logic pass2;
    } dp_flags_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               homed;
    } dp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_status_t;

    typedef struct packed {
        logic signed [31:0] stroke_max;
        logic signed [31:0] stroke_min;
        logic [30:0]        speed_limit;
        logic [30:0]        accel_limit;
        logic [30:0]        accel_recip;
        logic [30:0]        brake_window;
    } cfg_t;

    // program labels
    localparam step_t STEP_NONE   = 5'd0;
    localparam step_t STEP_TS     = 5'd6;
    localparam step_t STEP_POS    = 5'd15;
    localparam step_t STEP_SETPOS = 5'd17;

    function automatic ucode_t jsrg_ucode(input step_t step);
        ucode_t uc;
        uc = '{OP_NOP, C_NEXT, STEP_NONE, 1'b0};
        unique case (step)
            5'd0:  uc = '{OP_NOP,       C_NOT_TICK, STEP_SETPOS, 1'b0};
            5'd1:  uc = '{OP_TARGET,    C_NEXT,     STEP_NONE,   1'b0};
            5'd2:  uc = '{OP_ERR,       C_NEXT,     STEP_NONE,   1'b0};
            5'd3:  uc = '{OP_PRED,      C_NEXT,     STEP_NONE,   1'b0};
            5'd4:  uc = '{OP_BRAKE,     C_NEXT,     STEP_NONE,   1'b0};
            5'd5:  uc = '{OP_ACLAMP,    C_NEXT,     STEP_NONE,   1'b0};
            5'd6:  uc = '{OP_TS_ABS,    C_NEXT,     STEP_NONE,   1'b0};
            5'd7:  uc = '{OP_TS_MUL1,   C_NEXT,     STEP_NONE,   1'b0};
            5'd8:  uc = '{OP_TS_SPLIT,  C_NEXT,     STEP_NONE,   1'b0};
            5'd9:  uc = '{OP_TS_MUL2,   C_NEXT,     STEP_NONE,   1'b0};
            5'd10: uc = '{OP_TS_MUL3,   C_NEXT,     STEP_NONE,   1'b0};
            5'd11: uc = '{OP_TS_SUM,    C_NEXT,     STEP_NONE,   1'b0};
            5'd12: uc = '{OP_TS_SIGN,   C_PASS2,    STEP_POS,    1'b0};
            5'd13: uc = '{OP_VEL_ADD,   C_NEXT,     STEP_NONE,   1'b0};
            5'd14: uc = '{OP_VEL_CLAMP, C_ALWAYS,   STEP_TS,     1'b0};
            5'd15: uc = '{OP_POS_ADD,   C_NEXT,     STEP_NONE,   1'b0};
            5'd16: uc = '{OP_POS_CLIP,  C_NEXT,     STEP_NONE,   1'b1};
            5'd17: uc = '{OP_SET_POS,   C_NEXT,     STEP_NONE,   1'b1};
            default: uc = '{OP_NOP,     C_NEXT,     STEP_NONE,   1'b1};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

### rtl/core/jsrg_sequencer.sv
// ============================================================================
// jsrg_sequencer
// step counter, microprogram fetch and conditional jumps
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module jsrg_sequencer
    import jsrg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        out_free,
    input  wire dp_flags_t   flags,
    output dp_ctrl_t         ctrl,
    output seq_status_t      status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } seq_state_t;

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    ucode_t     uc;
    logic       jump;

    assign uc = jsrg_ucode(step_reg);

    always_comb
    begin
        unique case (uc.cond)
            C_NEXT:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NOT_TICK: jump = flags.not_tick;
            C_PASS2:    jump = flags.pass2;
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ctrl.load   = 1'b0;
        ctrl.op     = OP_NOP;
        status.done = 1'b0;
        status.busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                ctrl.op = uc.op;
                if (uc.last)
                    state_next = S_FINISH;
                else if (jump)
                    step_next = uc.target;
                else
                    step_next = step_reg + 5'd1;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    status.done = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/jsrg_datapath.sv
// ============================================================================
// jsrg_datapath
// working registers and arithmetic driven by the microprogram control word
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module jsrg_datapath
    import jsrg_pkg::*;
#(
    parameter int PERIOD_MS = PERIOD_MS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_ctrl_t           ctrl,
    input  wire cfg_t               cfg,
    input  wire logic [1:0]         in_func,
    input  wire logic signed [31:0] in_target,
    input  wire logic signed [31:0] in_setpos,
    output dp_flags_t               flags,
    output dp_state_t               state
);

    localparam int PW  = $clog2(PERIOD_MS + 1);
    localparam int APW = 22 + PW;
    localparam int BPW = 10 + PW;
    localparam int BQW = BPW + SMALL_M_W;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // architectural state
    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] vel_reg, vel_next;
    logic               homed_reg, homed_next;
    logic               pass_reg, pass_next;

    // working registers
    logic [1:0]         func_reg, func_next;
    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [31:0] setp_reg, setp_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [62:0] prod_reg, prod_next;
    logic signed [32:0] perr_reg, perr_next;
    logic signed [33:0] verr_reg, verr_next;
    logic signed [46:0] pquot_reg, pquot_next;
    logic signed [47:0] pred_reg, pred_next;
    logic signed [31:0] x_reg, x_next;
    logic [30:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [59:0]        qprod_reg, qprod_next;
    logic [21:0]        a_reg, a_next;
    logic [9:0]         b_reg, b_next;
    logic [APW-1:0]     ap_reg, ap_next;
    logic [BPW-1:0]     bp_reg, bp_next;
    logic [BQW-1:0]     bq_reg, bq_next;
    logic [30:0]        smag_reg, smag_next;
    logic signed [31:0] ts_reg, ts_next;
    logic signed [32:0] vsum_reg, vsum_next;

    // combinational helpers
    logic signed [31:0] t_hi, t_cl;
    logic signed [63:0] prod_full;
    logic signed [32:0] perr_calc;
    logic signed [33:0] verr_calc;
    logic signed [62:0] prod_adj;
    logic signed [47:0] pred_calc;
    logic [32:0]        perr_mag;
    logic signed [32:0] perr_neg;
    logic               in_window;
    logic signed [47:0] t48, smax48, smin48;
    logic signed [33:0] acc34, acc34_neg;
    logic               vel_pos, vel_neg;
    logic signed [33:0] vb, va1, va2;
    logic signed [31:0] x_neg;
    logic [21:0]        a_calc;
    logic [31:0]        a_times_div;
    logic [31:0]        b_full;
    logic [32:0]        smag_sum;
    logic [31:0]        smag_neg;
    logic signed [32:0] spd33, vc1, vc2;
    logic signed [32:0] psum;
    logic signed [31:0] psat;
    logic signed [31:0] p1, p2;
    logic signed [31:0] v1, v2;

    assign t_hi = (homed_reg && tgt_reg > cfg.stroke_max) ? cfg.stroke_max : tgt_reg;
    assign t_cl = (homed_reg && t_hi < cfg.stroke_min) ? cfg.stroke_min : t_hi;
    assign prod_full = vel_reg * $signed({1'b0, cfg.accel_recip});

    assign perr_calc = $signed({t_reg[31], t_reg}) - $signed({pos_reg[31], pos_reg});
    assign verr_calc = $signed({perr_calc[32], perr_calc})
                     - $signed({{2{vel_reg[31]}}, vel_reg});
    // truncate toward zero on the divide by 65536
    assign prod_adj  = prod_reg + $signed({47'd0, {16{prod_reg[62]}}});
    assign pred_calc = $signed({{16{pos_reg[31]}}, pos_reg})
                     + $signed({pquot_reg[46], pquot_reg});

    assign perr_neg  = -perr_reg;
    assign perr_mag  = perr_reg[32] ? perr_neg : perr_reg;
    assign in_window = perr_mag < {2'b00, cfg.brake_window};
    assign t48       = $signed({{16{t_reg[31]}}, t_reg});
    assign smax48    = $signed({{16{cfg.stroke_max[31]}}, cfg.stroke_max});
    assign smin48    = $signed({{16{cfg.stroke_min[31]}}, cfg.stroke_min});
    assign acc34     = $signed({3'b000, cfg.accel_limit});
    assign acc34_neg = -acc34;
    assign vel_pos   = !vel_reg[31] && (vel_reg != 32'sd0);
    assign vel_neg   = vel_reg[31];

    always_comb
    begin
        vb = verr_reg;
        if (in_window)
        begin
            if (vel_pos && pred_reg > t48)
                vb = acc34_neg;
            if (vel_neg && pred_reg < t48)
                vb = acc34;
        end
        if (homed_reg)
        begin
            if (pred_reg > smax48)
                vb = acc34_neg;
            if (pred_reg < smin48)
                vb = acc34;
        end
    end

    assign va1 = (verr_reg > acc34) ? acc34 : verr_reg;
    assign va2 = (va1 < acc34_neg) ? acc34_neg : va1;

    // time step: |x| * period / 1000 as quotient and remainder parts
    assign x_neg       = -x_reg;
    assign a_calc      = qprod_reg[59:DIV_SHIFT];
    assign a_times_div = 32'(a_calc) * 32'(TS_DIV);
    assign b_full      = 32'(mag_reg) - a_times_div;
    assign smag_sum    = 33'(ap_reg) + 33'(bq_reg >> SMALL_SHIFT);
    assign smag_neg    = -{1'b0, smag_reg};

    assign spd33 = $signed({2'b00, cfg.speed_limit});
    assign vc1   = (vsum_reg > spd33) ? spd33 : vsum_reg;
    assign vc2   = (vc1 < -spd33) ? -spd33 : vc1;

    assign psum = $signed({pos_reg[31], pos_reg}) + $signed({ts_reg[31], ts_reg});
    assign psat = (psum[32] != psum[31]) ? (psum[32] ? S32_MIN : S32_MAX) : psum[31:0];

    always_comb
    begin
        p1 = pos_reg;
        v1 = vel_reg;
        if (pos_reg > cfg.stroke_max)
        begin
            p1 = cfg.stroke_max;
            if (vel_pos)
                v1 = 32'sd0;
        end
        p2 = p1;
        v2 = v1;
        if (p1 < cfg.stroke_min)
        begin
            p2 = cfg.stroke_min;
            if (v1[31])
                v2 = 32'sd0;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        homed_next = homed_reg;
        pass_next  = pass_reg;
        func_next  = func_reg;
        tgt_next   = tgt_reg;
        setp_next  = setp_reg;
        t_next     = t_reg;
        prod_next  = prod_reg;
        perr_next  = perr_reg;
        verr_next  = verr_reg;
        pquot_next = pquot_reg;
        pred_next  = pred_reg;
        x_next     = x_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        qprod_next = qprod_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        ap_next    = ap_reg;
        bp_next    = bp_reg;
        bq_next    = bq_reg;
        smag_next  = smag_reg;
        ts_next    = ts_reg;
        vsum_next  = vsum_reg;
        if (ctrl.load)
        begin
            func_next = in_func;
            tgt_next  = in_target;
            setp_next = in_setpos;
        end
        unique case (ctrl.op)
            OP_NOP: ;
            OP_TARGET:
            begin
                t_next    = t_cl;
                prod_next = prod_full[62:0];
                pass_next = 1'b0;
            end
            OP_ERR:
            begin
                perr_next  = perr_calc;
                verr_next  = verr_calc;
                pquot_next = prod_adj[62:16];
            end
            OP_PRED:      pred_next = pred_calc;
            OP_BRAKE:     verr_next = vb;
            OP_ACLAMP:    x_next    = va2[31:0];
            OP_TS_ABS:
            begin
                mag_next = x_reg[31] ? x_neg[30:0] : x_reg[30:0];
                neg_next = x_reg[31];
            end
            OP_TS_MUL1:   qprod_next = 60'(mag_reg) * 60'(DIV_M);
            OP_TS_SPLIT:
            begin
                a_next = a_calc;
                b_next = b_full[9:0];
            end
            OP_TS_MUL2:
            begin
                ap_next = APW'(a_reg) * APW'(PERIOD_MS);
                bp_next = BPW'(b_reg) * BPW'(PERIOD_MS);
            end
            OP_TS_MUL3:   bq_next   = BQW'(bp_reg) * BQW'(SMALL_M);
            OP_TS_SUM:    smag_next = smag_sum[30:0];
            OP_TS_SIGN:   ts_next   = neg_reg ? $signed(smag_neg) : $signed({1'b0, smag_reg});
            OP_VEL_ADD:
                vsum_next = $signed({vel_reg[31], vel_reg}) + $signed({ts_reg[31], ts_reg});
            OP_VEL_CLAMP:
            begin
                vel_next  = vc2[31:0];
                x_next    = vc2[31:0];
                pass_next = 1'b1;
            end
            OP_POS_ADD:   pos_next = psat;
            OP_POS_CLIP:
            begin
                if (homed_reg)
                begin
                    pos_next = p2;
                    vel_next = v2;
                end
            end
            OP_SET_POS:
            begin
                if (func_reg == FUNC_HOME || func_reg == FUNC_FORCE)
                begin
                    pos_next = setp_reg;
                    vel_next = 32'sd0;
                end
                if (func_reg == FUNC_HOME)
                    homed_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            homed_reg <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            homed_reg <= homed_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        tgt_reg   <= tgt_next;
        setp_reg  <= setp_next;
        t_reg     <= t_next;
        prod_reg  <= prod_next;
        perr_reg  <= perr_next;
        verr_reg  <= verr_next;
        pquot_reg <= pquot_next;
        pred_reg  <= pred_next;
        x_reg     <= x_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        qprod_reg <= qprod_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        ap_reg    <= ap_next;
        bp_reg    <= bp_next;
        bq_reg    <= bq_next;
        smag_reg  <= smag_next;
        ts_reg    <= ts_next;
        vsum_reg  <= vsum_next;
    end

    assign flags.not_tick = (func_reg != FUNC_TICK);
    assign flags.pass2    = pass_reg;
    assign state.pos      = pos_reg;
    assign state.vel      = vel_reg;
    assign state.homed    = homed_reg;

endmodule

`default_nettype wire

### rtl/core/joint_setpoint_ramp_generator_core.sv
// ============================================================================
// joint_setpoint_ramp_generator_core
// trapezoidal setpoint ramp for one joint, Q16.16 position and velocity
// ============================================================================
// usage:
//   s_* takes one item per control period: tuser selects tick, home or force,
//   tdata carries target, load position, torque feed-forward, integrator limit.
//   m_* returns one result per item: commanded position and velocity plus the
//   two pass-through values in tdata, the homed flag in tuser.
//   cfg_we / cfg_index / cfg_wdata write the limit registers; the user must
//   do so only while idle, as the block itself does not enforce it.
// timing:
//   a tick runs 24 microprogram steps, the time-step routine being entered
//   twice; home and force take 2 steps. the next item can be taken in the
//   same cycle that the result of the last one becomes valid.
//   one item is in work at a time; s_tready is low while it runs.
// reset:
//   position, velocity and homed clear; limits take their reset values.
// stall:
//   a held result stays in the output register while the next item is
//   taken; a finished item waits in the finish state until the output frees.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module joint_setpoint_ramp_generator_core
    import jsrg_pkg::*;
#(
    parameter int PERIOD_MS = PERIOD_MS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // target_pos, set_position, torque_ff, integ_limit
    input  wire logic [1:0]   s_tuser,   // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // cmd_pos, cmd_vel, torque_ff_out, integ_limit_out
    output logic              m_tuser,   // is_homed
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    cfg_t        cfg_reg;
    dp_ctrl_t    ctrl;
    dp_flags_t   flags;
    dp_state_t   dp_state;
    seq_status_t seq_status;

    logic [31:0]  tq_reg;
    logic [31:0]  il_reg;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         out_homed_reg;
    logic         in_xfer;
    logic         out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = !seq_status.busy;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stroke_max   <= '0;
            cfg_reg.stroke_min   <= '0;
            cfg_reg.speed_limit  <= '0;
            cfg_reg.accel_limit  <= ACCEL_LIMIT_RST;
            cfg_reg.accel_recip  <= ACCEL_RECIP_RST;
            cfg_reg.brake_window <= BRAKE_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STROKE_MAX:  cfg_reg.stroke_max   <= cfg_wdata;
                REG_STROKE_MIN:  cfg_reg.stroke_min   <= cfg_wdata;
                REG_SPEED_LIMIT: cfg_reg.speed_limit  <= cfg_wdata[30:0];
                REG_ACCEL_LIMIT: cfg_reg.accel_limit  <= cfg_wdata[30:0];
                REG_ACCEL_RECIP: cfg_reg.accel_recip  <= cfg_wdata[30:0];
                REG_BRAKE_WIN:   cfg_reg.brake_window <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tq_reg <= s_tdata[95:64];
            il_reg <= s_tdata[127:96];
        end
        if (seq_status.done)
        begin
            out_data_reg  <= {il_reg, tq_reg, dp_state.vel, dp_state.pos};
            out_homed_reg <= dp_state.homed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (seq_status.done)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_homed_reg;

    jsrg_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl),
        .status   (seq_status)
    );

    jsrg_datapath #(
        .PERIOD_MS (PERIOD_MS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .in_func   (s_tuser),
        .in_target (s_tdata[31:0]),
        .in_setpos (s_tdata[63:32]),
        .flags     (flags),
        .state     (dp_state)
    );

    // a result only completes into a free output slot
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_status.done |-> out_free)
        else $error("result completed into an occupied output register");

    // one item in work at a time
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("input taken while an item is in work");

    // a completed item shows up on the output
    a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
        seq_status.done |=> m_tvalid)
        else $error("completed result not presented");

endmodule

`default_nettype wire
